### sv/hse_pkg.sv
// Shared constants, datapath operation codes and controller/datapath bundles.
package hse_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned DataW    = 32;

  // One operation per cycle, issued by the controller to the datapath.
  typedef enum logic [3:0] {
    OpNone,
    OpStore,
    OpBuildInit,
    OpBuildStep,
    OpSiftLoad,
    OpSiftCmp,
    OpSortInit,
    OpSortStep,
    OpSortSwap,
    OpEmitInit,
    OpEmitRead,
    OpEmitLoad,
    OpClear
  } hse_op_e;

  typedef struct packed {
    hse_op_e op;
  } hse_cmd_t;

  typedef struct packed {
    logic i_zero;     // loop index is zero
    logic i_le1;      // loop index is zero or one
    logic emit_done;  // every stored word has been read out
    logic sift_done;  // current sift-down level settles the element
    logic out_free;   // output register is empty or drains this cycle
  } hse_status_t;

endpackage

### sv/hse_chan_if.sv
// Valid/ready channel interfaces: input words, result words, configuration writes.
interface hse_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hse_pkg::DataW-1:0]    item_value;
  logic                                is_last;

  modport source (output valid, item_value, is_last, input ready);
  modport sink   (input valid, item_value, is_last, output ready);
endinterface

interface hse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hse_pkg::DataW-1:0]    sorted_value;
  logic                                is_last_res;
  logic                                overflow;

  modport source (output valid, sorted_value, is_last_res, overflow, input ready);
  modport sink   (input valid, sorted_value, is_last_res, overflow, output ready);
endinterface

interface hse_cfg_if;
  logic valid;
  logic ready;
  logic sort_descending;

  modport source (output valid, sort_descending, input ready);
  modport sink   (input valid, sort_descending, output ready);
endinterface

### sv/hse_datapath.sv
// Heap sort datapath: value memory, loop counters, sift-down compare and output register.
module hse_datapath #(
  parameter int unsigned MAX_ITEMS = hse_pkg::MaxItems
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hse_pkg::hse_cmd_t                 cmd_i,
  output hse_pkg::hse_status_t              status_o,
  input  logic signed [hse_pkg::DataW-1:0]  in_value_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_desc_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [hse_pkg::DataW-1:0]  out_value_o,
  output logic                              out_last_o,
  output logic                              out_ovf_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned XW = CW + 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);

  logic signed [hse_pkg::DataW-1:0] mem [MAX_ITEMS];

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          desc_q, desc_d;
  logic          out_valid_q, out_valid_d;

  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] size_q, size_d;
  logic [IW-1:0] root_q, root_d;
  logic signed [hse_pkg::DataW-1:0] cur_q, cur_d;
  logic signed [hse_pkg::DataW-1:0] rda_q, rdb_q;
  logic signed [hse_pkg::DataW-1:0] out_value_q, out_value_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  logic [IW-1:0] ra, rb, wa;
  logic          we;
  logic signed [hse_pkg::DataW-1:0] wd;

  logic [CW-1:0] i_dec, i_inc;
  logic [XW-1:0] lidx, ridx, child_idx, nl, nr;
  logic          l_ok, r_ok, take_l, take_r, move;
  logic signed [hse_pkg::DataW-1:0] best_lc, child_val;

  // a belongs nearer the heap root than b
  function automatic logic ranks_above(input logic signed [hse_pkg::DataW-1:0] a,
                                       input logic signed [hse_pkg::DataW-1:0] b,
                                       input logic desc);
    ranks_above = desc ? (b > a) : (a > b);
  endfunction

  assign i_dec = i_q - CW'(1);
  assign i_inc = i_q + CW'(1);

  // Children of the current hole; the sifting element itself lives in cur_q.
  assign lidx    = (XW'(root_q) << 1) | XW'(1);
  assign ridx    = lidx + XW'(1);
  assign l_ok    = lidx < XW'(size_q);
  assign r_ok    = ridx < XW'(size_q);
  assign take_l  = l_ok && ranks_above(rda_q, cur_q, desc_q);
  assign best_lc = take_l ? rda_q : cur_q;
  assign take_r  = r_ok && ranks_above(rdb_q, best_lc, desc_q);
  assign move    = take_l || take_r;
  assign child_idx = take_r ? ridx : lidx;
  assign child_val = take_r ? rdb_q : rda_q;
  assign nl      = (XW'(child_idx[IW-1:0]) << 1) | XW'(1);
  assign nr      = nl + XW'(1);

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    desc_d      = cfg_we_i ? cfg_desc_i : desc_q;
    i_d         = i_q;
    size_d      = size_q;
    root_d      = root_q;
    cur_d       = cur_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    ra          = lidx[IW-1:0];
    rb          = ridx[IW-1:0];
    we          = 1'b0;
    wa          = root_q;
    wd          = cur_q;
    case (cmd_i.op)
      hse_pkg::OpStore: begin
        if (cnt_q < MaxCnt) begin
          we    = 1'b1;
          wa    = cnt_q[IW-1:0];
          wd    = in_value_i;
          cnt_d = cnt_q + CW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      hse_pkg::OpBuildInit: begin
        i_d    = cnt_q >> 1;
        size_d = cnt_q;
      end
      hse_pkg::OpBuildStep: begin
        ra     = i_dec[IW-1:0];
        root_d = i_dec[IW-1:0];
        i_d    = i_dec;
      end
      hse_pkg::OpSiftLoad: begin
        cur_d = rda_q;
      end
      hse_pkg::OpSiftCmp: begin
        we = 1'b1;
        wa = root_q;
        wd = move ? child_val : cur_q;
        if (move) begin
          root_d = child_idx[IW-1:0];
          ra     = nl[IW-1:0];
          rb     = nr[IW-1:0];
        end
      end
      hse_pkg::OpSortInit: begin
        i_d = cnt_q;
      end
      hse_pkg::OpSortStep: begin
        ra     = '0;
        rb     = i_dec[IW-1:0];
        size_d = i_dec;
        root_d = '0;
        i_d    = i_dec;
      end
      hse_pkg::OpSortSwap: begin
        // top of heap goes to the freed tail slot, the tail element sifts from the root
        we    = 1'b1;
        wa    = i_q[IW-1:0];
        wd    = rda_q;
        cur_d = rdb_q;
      end
      hse_pkg::OpEmitInit: begin
        i_d = '0;
      end
      hse_pkg::OpEmitRead: begin
        ra = i_q[IW-1:0];
      end
      hse_pkg::OpEmitLoad: begin
        out_value_d = rda_q;
        out_last_d  = (i_inc == cnt_q);
        out_ovf_d   = ovf_q;
        out_valid_d = 1'b1;
        i_d         = i_inc;
      end
      hse_pkg::OpClear: begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rda_q <= mem[ra];
    rdb_q <= mem[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      desc_q      <= desc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    size_q      <= size_d;
    root_q      <= root_d;
    cur_q       <= cur_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign status_o.i_zero    = (i_q == '0);
  assign status_o.i_le1     = (i_q <= CW'(1));
  assign status_o.emit_done = (i_q == cnt_q);
  assign status_o.sift_done = !move;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("stored count beyond capacity");

  a_sift_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == hse_pkg::OpSiftCmp) |-> (CW'(root_q) < size_q))
    else $error("sift hole outside heap");

  a_out_free_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == hse_pkg::OpEmitLoad) |-> !out_valid_q)
    else $error("output register overwritten");

endmodule

### sv/hse_ctrl.sv
// Heap sort sequencer: collect, heap build, sort-down and emit phases.
module hse_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  input  hse_pkg::hse_status_t  status_i,
  output logic                  in_ready_o,
  output hse_pkg::hse_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_COLLECT,
    S_BUILD_INIT,
    S_BUILD_CHK,
    S_SIFT_LD,
    S_SIFT_CMP,
    S_SORT_INIT,
    S_SORT_CHK,
    S_SORT_SWP,
    S_EMIT_INIT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

  state_e state_q, state_d;
  logic   sorting_q, sorting_d;  // sift returns to sort-down instead of heap build

  assign in_ready_o = (state_q == S_COLLECT);

  always_comb begin
    state_d    = state_q;
    sorting_d  = sorting_q;
    cmd_o.op   = hse_pkg::OpNone;
    case (state_q)
      S_COLLECT: begin
        if (in_valid_i) begin
          cmd_o.op = hse_pkg::OpStore;
          if (in_last_i) begin
            state_d = S_BUILD_INIT;
          end
        end
      end
      S_BUILD_INIT: begin
        cmd_o.op  = hse_pkg::OpBuildInit;
        sorting_d = 1'b0;
        state_d   = S_BUILD_CHK;
      end
      S_BUILD_CHK: begin
        if (status_i.i_zero) begin
          state_d = S_SORT_INIT;
        end else begin
          cmd_o.op = hse_pkg::OpBuildStep;
          state_d  = S_SIFT_LD;
        end
      end
      S_SIFT_LD: begin
        cmd_o.op = hse_pkg::OpSiftLoad;
        state_d  = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        cmd_o.op = hse_pkg::OpSiftCmp;
        if (status_i.sift_done) begin
          state_d = sorting_q ? S_SORT_CHK : S_BUILD_CHK;
        end
      end
      S_SORT_INIT: begin
        cmd_o.op  = hse_pkg::OpSortInit;
        sorting_d = 1'b1;
        state_d   = S_SORT_CHK;
      end
      S_SORT_CHK: begin
        if (status_i.i_le1) begin
          state_d = S_EMIT_INIT;
        end else begin
          cmd_o.op = hse_pkg::OpSortStep;
          state_d  = S_SORT_SWP;
        end
      end
      S_SORT_SWP: begin
        cmd_o.op = hse_pkg::OpSortSwap;
        state_d  = S_SIFT_CMP;
      end
      S_EMIT_INIT: begin
        cmd_o.op = hse_pkg::OpEmitInit;
        state_d  = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        if (status_i.emit_done) begin
          cmd_o.op = hse_pkg::OpClear;
          state_d  = S_COLLECT;
        end else if (status_i.out_free) begin
          cmd_o.op = hse_pkg::OpEmitRead;
          state_d  = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd_o.op = hse_pkg::OpEmitLoad;
        state_d  = S_EMIT_RD;
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      sorting_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sorting_q <= sorting_d;
    end
  end

  a_last_starts_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_last_i) |=> (state_q == S_BUILD_INIT))
    else $error("last word did not start the sort");

  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_LD) |-> ($past(state_q) == S_EMIT_RD))
    else $error("emit load without a preceding read");

endmodule

### sv/heap_sort_engine.sv
// Heap sort engine top level: channels, configuration register port, sequencer and datapath.
//
// The engine collects signed 32-bit words, one per cycle, until a word marked
// last, then heap-sorts them in place and streams them out with the final word
// marked. sort_descending = 0 gives ascending order (max-heap), 1 descending
// (min-heap); it is read while the sort runs. At most MAX_ITEMS words are kept
// per set; extra words are dropped and every result word of that set carries
// overflow = 1. Timing: input is taken at one word per cycle until the last
// word; the block then stops taking input for the whole sort and emit. Heap
// build checks and loads each inner node, then compares once per level
// sifted; each sort-down step checks and swaps, then compares once per level
// sifted (at most log2 N); emit reads and then loads each word. The sift pace
// is set by the single value memory, which offers two reads and one write per
// cycle, so one heap level is handled per cycle. The output word sits in a
// register, so the engine keeps working while the sink stalls, apart from the
// emit step that needs the register free. The memory needs no clearing after
// reset; configuration writes are taken in every cycle.
module heap_sort_engine #(
  parameter int unsigned MAX_ITEMS = hse_pkg::MaxItems
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  hse_in_if.sink    items_i,
  hse_out_if.source results_o,
  hse_cfg_if.sink   cfg_i
);

  hse_pkg::hse_cmd_t    cmd;
  hse_pkg::hse_status_t status;
  logic                 in_ready;

  // The single register is always writable.
  assign cfg_i.ready   = 1'b1;
  assign items_i.ready = in_ready;

  hse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (items_i.valid),
    .in_last_i  (items_i.is_last),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  hse_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (items_i.item_value),
    .cfg_we_i    (cfg_i.valid),
    .cfg_desc_i  (cfg_i.sort_descending),
    .out_ready_i (results_o.ready),
    .out_valid_o (results_o.valid),
    .out_value_o (results_o.sorted_value),
    .out_last_o  (results_o.is_last_res),
    .out_ovf_o   (results_o.overflow)
  );

endmodule

### test/heap_sort_engine_checker.sv
// Scoreboard for the heap sort engine: rebuilds each sorted set and checks every result word.
`timescale 1ns / 1ps
module heap_sort_engine_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  hse_in_if           items_i,
  hse_out_if          results_i,
  hse_cfg_if          cfg_i,
  output int unsigned error_count_o,
  output int unsigned words_due_o,
  output int unsigned words_checked_o
);

  localparam int unsigned DataW    = hse_pkg::DataW;
  localparam int unsigned MaxItems = hse_pkg::MaxItems;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
    logic                    overflow;
  } sorted_word_t;

  logic signed [DataW-1:0] held_words [MaxItems];
  int unsigned             held_count;
  logic                    words_dropped;
  logic                    descending;
  sorted_word_t            sorted_q [$];

  // max-heap for ascending output, min-heap for descending
  function automatic logic nearer_root(input logic signed [DataW-1:0] a,
                                       input logic signed [DataW-1:0] b);
    return descending ? (a < b) : (a > b);
  endfunction

  function automatic void sift_down(input int unsigned heap_len, input int unsigned start);
    int unsigned node;
    int unsigned pick;
    int unsigned child;
    logic signed [DataW-1:0] tmp;
    node = start;
    while (1) begin
      pick  = node;
      child = 2 * node + 1;
      if (child < heap_len && nearer_root(held_words[child], held_words[pick])) pick = child;
      child = 2 * node + 2;
      if (child < heap_len && nearer_root(held_words[child], held_words[pick])) pick = child;
      if (pick == node) return;
      tmp              = held_words[node];
      held_words[node] = held_words[pick];
      held_words[pick] = tmp;
      node             = pick;
    end
  endfunction

  function automatic void sort_held_set();
    int unsigned i;
    sorted_word_t w;
    logic signed [DataW-1:0] tmp;
    for (i = held_count / 2; i > 0; i--) sift_down(held_count, i - 1);
    for (i = held_count; i > 1; i--) begin
      tmp               = held_words[0];
      held_words[0]     = held_words[i - 1];
      held_words[i - 1] = tmp;
      sift_down(i - 1, 0);
    end
    for (i = 0; i < held_count; i++) begin
      w.value    = held_words[i];
      w.last     = (i + 1 == held_count);
      w.overflow = words_dropped;
      sorted_q.push_back(w);
    end
    held_count    = 0;
    words_dropped = 1'b0;
  endfunction

  function automatic void flag(input string field, input longint exp_v, input longint act_v);
    error_count_o++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    sorted_word_t exp_w;
    if (!rst_ni) begin
      held_count      = 0;
      words_dropped   = 1'b0;
      descending      = 1'b0;
      error_count_o   = 0;
      words_due_o     = 0;
      words_checked_o = 0;
      sorted_q.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) descending = cfg_i.sort_descending;

      if (results_i.valid && results_i.ready) begin
        words_checked_o++;
        if (sorted_q.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected result word, expected none, actual %0d", $time,
                   results_i.sorted_value);
        end else begin
          exp_w = sorted_q.pop_front();
          if (results_i.sorted_value !== exp_w.value)
            flag("sorted_value", exp_w.value, results_i.sorted_value);
          if (results_i.is_last_res !== exp_w.last)
            flag("is_last_res", exp_w.last, results_i.is_last_res);
          if (results_i.overflow !== exp_w.overflow)
            flag("overflow", exp_w.overflow, results_i.overflow);
        end
      end

      if (items_i.valid && items_i.ready) begin
        if (held_count < MaxItems) begin
          held_words[held_count] = items_i.item_value;
          held_count++;
        end else begin
          words_dropped = 1'b1;
        end
        if (items_i.is_last) sort_held_set();
      end

      words_due_o = sorted_q.size();
    end
  end

endmodule

### test/heap_sort_engine_tb.sv
// Testbench top for the heap sort engine: clock, reset, word and order stimulus, verdict.
`timescale 1ns / 1ps
module heap_sort_engine_tb;

  localparam int unsigned DataW      = hse_pkg::DataW;
  localparam int unsigned MaxItems   = hse_pkg::MaxItems;
  localparam int unsigned WordTarget = 430;
  localparam int unsigned CalmFrom   = 370;           // no idling once this many words went in
  localparam int unsigned Settle     = 16;            // cycles after the last result word
  localparam int unsigned Drain      = 40;            // quiet cycles before the verdict
  localparam int unsigned FullSet    = MaxItems;      // fills the store exactly
  localparam int unsigned OverSet    = MaxItems + 3;  // last word itself gets dropped

  localparam logic signed [DataW-1:0] MinWord = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] MaxWord = {1'b0, {(DataW-1){1'b1}}};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  hse_in_if  items_if ();
  hse_out_if results_if ();
  hse_cfg_if cfg_if ();

  heap_sort_engine u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .items_i   (items_if),
    .results_o (results_if),
    .cfg_i     (cfg_if)
  );

  int unsigned error_count;
  int unsigned words_due;
  int unsigned words_checked;

  // scoreboard sits beside the engine and only watches the three channels
  heap_sort_engine_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .items_i         (items_if),
    .results_i       (results_if),
    .cfg_i           (cfg_if),
    .error_count_o   (error_count),
    .words_due_o     (words_due),
    .words_checked_o (words_checked)
  );

  bit          idle_off;      // set for the tail of the run: no gaps, no stalls
  int unsigned send_calm;     // words left in a gap-free stretch on the input side
  int unsigned words_sent;
  int unsigned words_in_set;
  int unsigned sets_sent;
  int unsigned over_sets;
  int unsigned order_writes;

  // Mostly full-range random words; some extremes and a narrow band so that
  // sets carry duplicate keys.
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MinWord;
      1:       return MaxWord;
      2, 3:    return DataW'($urandom_range(0, 10)) - DataW'(5);
      default: return $urandom;
    endcase
  endfunction

  // Offer one input word, now and then after a short gap. The handshake is
  // judged from ready sampled mid-cycle, so no race with the engine's flops.
  task automatic send_word(input logic signed [DataW-1:0] value, input logic last);
    logic took;
    if (!idle_off && send_calm == 0 && $urandom_range(0, 3) == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
      send_calm = $urandom_range(0, 12);
    end else if (send_calm != 0) begin
      send_calm--;
    end
    items_if.valid      <= 1'b1;
    items_if.item_value <= value;
    items_if.is_last    <= last;
    do begin
      @(negedge clk);
      took = items_if.ready;
      @(posedge clk);
    end while (!took);
    words_sent++;
    words_in_set++;
    if (last) begin
      sets_sent++;
      if (words_in_set > MaxItems) over_sets++;
      words_in_set = 0;
    end
  endtask

  // Order bit is only rewritten with the engine idle: every result word of
  // the previous set drained, then a settle pause for the clear-out steps.
  // The count is first looked at mid-cycle, after the scoreboard took in the
  // word just accepted.
  task automatic set_order(input logic desc);
    logic took;
    items_if.valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
    repeat (Settle) @(posedge clk);
    cfg_if.valid           <= 1'b1;
    cfg_if.sort_descending <= desc;
    do begin
      @(negedge clk);
      took = cfg_if.ready;
      @(posedge clk);
    end while (!took);
    cfg_if.valid <= 1'b0;
    order_writes++;
  endtask

  // Result side back-pressure: ready drops low at random between
  // stretches of free flow.
  initial begin : sink_pacing
    int unsigned hold;
    int unsigned calm;
    results_if.ready = 1'b0;
    hold = 0;
    calm = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        if (hold == 0) begin
          results_if.ready <= 1'b1;
          calm = $urandom_range(0, 24);
        end
      end else if (calm != 0) begin
        calm--;
        results_if.ready <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 2) == 0) begin
        results_if.ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned set_no;
    int unsigned set_len;
    int unsigned k;
    items_if.valid         = 1'b0;
    items_if.item_value    = '0;
    items_if.is_last       = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.sort_descending = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: both range ends, zero, -1 and 1 in ascending order
    set_order(1'b0);
    send_word(MaxWord, 1'b0);
    send_word(MinWord, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b0);
    send_word(MinWord, 1'b1);

    // directed: duplicate keys mixed with extremes, descending
    set_order(1'b1);
    send_word(5, 1'b0);
    send_word(5, 1'b0);
    send_word(-5, 1'b0);
    send_word(MaxWord, 1'b0);
    send_word(MinWord, 1'b0);
    send_word(5, 1'b1);
    // one-word set
    send_word(-1, 1'b1);

    // directed: a pair of equal keys, then a lone minimum, ascending again
    set_order(1'b0);
    send_word(3, 1'b0);
    send_word(3, 1'b1);
    send_word(MinWord, 1'b1);

    // random sets: mostly short, a few mid-size, one exactly full, one past
    // capacity where the marked-last word is among the dropped ones
    set_no = 0;
    while (words_sent < WordTarget) begin
      if (set_no == 2)
        set_len = FullSet;
      else if (set_no == 6)
        set_len = OverSet;
      else if ($urandom_range(0, 9) == 0)
        set_len = $urandom_range(13, 40);
      else
        set_len = $urandom_range(1, 12);
      for (k = 1; k <= set_len; k++) send_word(pick_value(), k == set_len);
      set_no++;
      if (words_sent >= CalmFrom) idle_off = 1'b1;
      if ($urandom_range(0, 3) == 0) set_order(1'($urandom_range(0, 1)));
    end

    items_if.valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
    repeat (Drain) @(posedge clk);

    $display("Covered %0d sets (%0d past capacity) from %0d input words, %0d order writes,",
             sets_sent, over_sets, words_sent, order_writes);
    $display("with %0d result words checked and %0d mismatches.", words_checked, error_count);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // hard stop, far beyond the slowest correct run
  initial begin : watchdog
    #3ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
